// File: design/i2c_master_byte_engine_core_defines.svh
// Assertion macros shared by the I2C master byte engine RTL.
// Needs a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define I2CBE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define I2CBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/i2cbe_pkg.sv
// Types and constants for the I2C master byte engine.
// Used by the front decoder, the queue, the sequencer and the top level.
package i2cbe_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned HalfWidth = 16;
  localparam int unsigned AddrWidth = 7;

  typedef enum logic [0:0] {
    REG_HALF_PERIOD = 1'd0,
    REG_DEV_ADDR    = 1'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_READ  = 3'd4,
    MODE_ADDR  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'b000,
    CMD_START = 3'b001,
    CMD_STOP  = 3'b010,
    CMD_WRITE = 3'b011,
    CMD_READ  = 3'b100
  } cmd_e;

  typedef enum logic [13:0] {
    PH_IDLE      = 14'b00000000000001,
    PH_STA_REL   = 14'b00000000000010,
    PH_STA_HIGH  = 14'b00000000000100,
    PH_STA_HOLD  = 14'b00000000001000,
    PH_STO_LOW   = 14'b00000000010000,
    PH_STO_HIGH  = 14'b00000000100000,
    PH_WR_LOW    = 14'b00000001000000,
    PH_WR_HIGH   = 14'b00000010000000,
    PH_WACK_LOW  = 14'b00000100000000,
    PH_WACK_HIGH = 14'b00001000000000,
    PH_RD_LOW    = 14'b00010000000000,
    PH_RD_HIGH   = 14'b00100000000000,
    PH_RACK_LOW  = 14'b01000000000000,
    PH_RACK_HIGH = 14'b10000000000000
  } phase_e;

  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       ack_out;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic scl;
    logic en;
    logic lvl;
  } pins_t;

  typedef struct packed {
    pins_t      pins;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_in;
  } result_t;

endpackage

// File: design/i2cbe_front.sv
// Front decoder: turns one input transfer into a queue item.
// Depends on i2cbe_pkg; folds send address into a byte write.
module i2cbe_front (
  input  logic [2:0]                       mode_i,
  input  logic [7:0]                       tx_byte_i,
  input  logic                             ack_out_i,
  input  logic                             read_not_write_i,
  input  logic                             sda_line_i,
  input  logic [i2cbe_pkg::AddrWidth-1:0]  dev_addr_i,
  output i2cbe_pkg::item_t                 item_o
);
  import i2cbe_pkg::*;

  always_comb begin
    item_o.cmd     = CMD_NONE;
    item_o.data    = tx_byte_i;
    item_o.ack_out = ack_out_i;
    item_o.sda     = sda_line_i;
    unique case (mode_i)
      MODE_START: item_o.cmd = CMD_START;
      MODE_STOP:  item_o.cmd = CMD_STOP;
      MODE_WRITE: item_o.cmd = CMD_WRITE;
      MODE_READ:  item_o.cmd = CMD_READ;
      MODE_ADDR: begin
        item_o.cmd  = CMD_WRITE;
        item_o.data = {dev_addr_i, read_not_write_i};
      end
      default:    item_o.cmd = CMD_NONE;
    endcase
  end

endmodule

// File: design/i2cbe_queue.sv
// Two-entry queue between the front decoder and the sequencer.
// Depends on i2cbe_pkg for the item type.
module i2cbe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cbe_pkg::item_t  push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output i2cbe_pkg::item_t  pop_item_o
);
  import i2cbe_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: design/i2cbe_back.sv
// Bus sequencer: advances the phase machine by one tick per queue item.
// Depends on i2cbe_pkg; holds the result in an output register.
module i2cbe_back #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [TICK_WIDTH-1:0]   half_ticks_i,
  input  logic                    item_valid_i,
  input  i2cbe_pkg::item_t        item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output i2cbe_pkg::result_t      result_o
);
  import i2cbe_pkg::*;

  phase_e                ph_q, ph_d;
  logic [3:0]            bc_q, bc_d;
  logic [7:0]            sh_q, sh_d;
  logic [TICK_WIDTH-1:0] tk_q, tk_d, tk_n, h_eff;
  logic [7:0]            rx_q, rx_d;
  logic                  sack_q, sack_d;
  logic                  ackh_q, ackh_d;
  pins_t                 pins_q, pins_d;
  logic                  done, do_enter;
  logic                  out_valid_q;
  result_t               res_q;

  function automatic pins_t enter_pins(phase_e ph, logic scl, logic msb, logic ackh);
    pins_t p;
    p = '{scl: 1'b0, en: 1'b0, lvl: 1'b0};
    unique case (ph)
      PH_STA_REL:   p = '{scl: scl,  en: 1'b0, lvl: 1'b0};
      PH_STA_HIGH:  p = '{scl: 1'b1, en: 1'b0, lvl: 1'b0};
      PH_STA_HOLD:  p = '{scl: 1'b1, en: 1'b1, lvl: 1'b0};
      PH_STO_LOW:   p = '{scl: 1'b0, en: 1'b1, lvl: 1'b0};
      PH_STO_HIGH:  p = '{scl: 1'b1, en: 1'b1, lvl: 1'b0};
      PH_WR_LOW:    p = '{scl: 1'b0, en: 1'b1, lvl: msb};
      PH_WR_HIGH:   p = '{scl: 1'b1, en: 1'b1, lvl: msb};
      PH_WACK_HIGH: p = '{scl: 1'b1, en: 1'b0, lvl: 1'b0};
      PH_RD_HIGH:   p = '{scl: 1'b1, en: 1'b0, lvl: 1'b0};
      PH_RACK_LOW:  p = '{scl: 1'b0, en: 1'b1, lvl: ackh};
      PH_RACK_HIGH: p = '{scl: 1'b1, en: 1'b1, lvl: ackh};
      default:      p = '{scl: 1'b0, en: 1'b0, lvl: 1'b0};
    endcase
    return p;
  endfunction

  assign pop_o       = item_valid_i && (!out_valid_q || out_ready_i);
  assign h_eff       = (half_ticks_i == '0) ? {{(TICK_WIDTH-1){1'b0}}, 1'b1} : half_ticks_i;
  assign tk_n        = tk_q + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    ph_d     = ph_q;
    bc_d     = bc_q;
    sh_d     = sh_q;
    tk_d     = tk_q;
    rx_d     = rx_q;
    sack_d   = sack_q;
    ackh_d   = ackh_q;
    pins_d   = pins_q;
    done     = 1'b0;
    do_enter = 1'b0;
    if (ph_q == PH_IDLE) begin
      unique case (item_i.cmd)
        CMD_START: begin
          ph_d     = PH_STA_REL;
          do_enter = 1'b1;
        end
        CMD_STOP: begin
          ph_d     = PH_STO_LOW;
          do_enter = 1'b1;
        end
        CMD_WRITE: begin
          sh_d     = item_i.data;
          bc_d     = 4'd0;
          ph_d     = PH_WR_LOW;
          do_enter = 1'b1;
        end
        CMD_READ: begin
          sh_d     = 8'd0;
          bc_d     = 4'd0;
          ackh_d   = item_i.ack_out;
          ph_d     = PH_RD_LOW;
          do_enter = 1'b1;
        end
        default: ph_d = PH_IDLE;
      endcase
    end else if (tk_n >= h_eff) begin
      unique case (ph_q)
        PH_STA_REL: begin
          ph_d     = PH_STA_HIGH;
          do_enter = 1'b1;
        end
        PH_STA_HIGH: begin
          ph_d     = PH_STA_HOLD;
          do_enter = 1'b1;
        end
        PH_STA_HOLD: begin
          ph_d   = PH_IDLE;
          pins_d = '{scl: 1'b0, en: 1'b1, lvl: 1'b0};
          done   = 1'b1;
        end
        PH_STO_LOW: begin
          ph_d     = PH_STO_HIGH;
          do_enter = 1'b1;
        end
        PH_STO_HIGH: begin
          ph_d   = PH_IDLE;
          pins_d = '{scl: 1'b1, en: 1'b0, lvl: 1'b0};
          done   = 1'b1;
        end
        PH_WR_LOW: begin
          ph_d     = PH_WR_HIGH;
          do_enter = 1'b1;
        end
        PH_WR_HIGH: begin
          sh_d     = {sh_q[6:0], 1'b0};
          bc_d     = bc_q + 4'd1;
          ph_d     = (bc_d >= BitsPerByte) ? PH_WACK_LOW : PH_WR_LOW;
          do_enter = 1'b1;
        end
        PH_WACK_LOW: begin
          ph_d     = PH_WACK_HIGH;
          do_enter = 1'b1;
        end
        PH_WACK_HIGH: begin
          sack_d = item_i.sda;
          ph_d   = PH_IDLE;
          pins_d = '{scl: 1'b0, en: 1'b0, lvl: 1'b0};
          done   = 1'b1;
        end
        PH_RD_LOW: begin
          ph_d     = PH_RD_HIGH;
          do_enter = 1'b1;
        end
        PH_RD_HIGH: begin
          sh_d = {sh_q[6:0], item_i.sda};
          bc_d = bc_q + 4'd1;
          if (bc_d >= BitsPerByte) begin
            rx_d = sh_d;
            ph_d = PH_RACK_LOW;
          end else begin
            ph_d = PH_RD_LOW;
          end
          do_enter = 1'b1;
        end
        PH_RACK_LOW: begin
          ph_d     = PH_RACK_HIGH;
          do_enter = 1'b1;
        end
        PH_RACK_HIGH: begin
          ph_d   = PH_IDLE;
          pins_d = '{scl: 1'b0, en: 1'b1, lvl: ackh_q};
          done   = 1'b1;
        end
        default: ph_d = PH_IDLE;
      endcase
    end else begin
      tk_d = tk_n;
    end
    if (do_enter) begin
      tk_d   = '0;
      pins_d = enter_pins(ph_d, pins_q.scl, sh_d[7], ackh_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      bc_q        <= 4'd0;
      sh_q        <= 8'd0;
      tk_q        <= '0;
      rx_q        <= 8'd0;
      sack_q      <= 1'b0;
      ackh_q      <= 1'b0;
      pins_q      <= '{scl: 1'b1, en: 1'b0, lvl: 1'b0};
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      ph_q        <= ph_d;
      bc_q        <= bc_d;
      sh_q        <= sh_d;
      tk_q        <= tk_d;
      rx_q        <= rx_d;
      sack_q      <= sack_d;
      ackh_q      <= ackh_d;
      pins_q      <= pins_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q.pins    <= pins_d;
      res_q.busy    <= (ph_d != PH_IDLE);
      res_q.done    <= done;
      res_q.rx_byte <= rx_d;
      res_q.ack_in  <= sack_d;
    end
  end

endmodule

// File: design/i2c_master_byte_engine_core.sv
// I2C master byte engine, top level.
// Each input transfer is one tick of the bus timebase with an optional command
// (start, stop, write byte, read byte, send address) and the sampled SDA level.
// Each tick yields exactly one output transfer: the SCL and SDA pin drive, busy,
// a done pulse, the last received byte and the last slave ack.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 half period in ticks, 1 device address) on the same clock edge.
// A decoder classifies each tick and places it in a two-entry queue; the
// sequencer takes one tick per cycle from the queue while the output is not stalled, and registers its result.
// A tick passes through the queue and then the result register before it reaches the output.
// Throughput: one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the queue fills, and
// in_ready_o drops once the queue is full; no tick is lost or repeated.
// Reset leaves the sequencer idle with its SCL state high and SDA released, the half period
// at five ticks and the device address at zero; the result register itself is not reset.
module i2c_master_byte_engine_core #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [i2cbe_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      mode_i,
  input  logic [7:0]                      tx_byte_i,
  input  logic                            ack_out_i,
  input  logic                            read_not_write_i,
  input  logic                            sda_line_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            scl_level_o,
  output logic                            sda_enable_o,
  output logic                            sda_level_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [7:0]                      rx_byte_o,
  output logic                            ack_in_o
);
  import i2cbe_pkg::*;

  `include "i2c_master_byte_engine_core_defines.svh"

  logic [HalfWidth-1:0]            half_q;
  logic [AddrWidth-1:0]            addr_q;
  logic [HalfWidth+TICK_WIDTH-1:0] half_ext;
  logic [TICK_WIDTH-1:0]           half_ticks;
  item_t                           front_item, queue_item;
  logic                            queue_full, queue_valid, queue_pop;
  result_t                         result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfWidth'(5);
      addr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HALF_PERIOD: half_q <= cfg_data_i[HalfWidth-1:0];
        REG_DEV_ADDR:    addr_q <= cfg_data_i[AddrWidth-1:0];
        default:         half_q <= half_q;
      endcase
    end
  end

  assign half_ext   = {{TICK_WIDTH{1'b0}}, half_q};
  assign half_ticks = half_ext[TICK_WIDTH-1:0];
  assign in_ready_o = !queue_full;

  i2cbe_front u_front (
    .mode_i           (mode_i),
    .tx_byte_i        (tx_byte_i),
    .ack_out_i        (ack_out_i),
    .read_not_write_i (read_not_write_i),
    .sda_line_i       (sda_line_i),
    .dev_addr_i       (addr_q),
    .item_o           (front_item)
  );

  i2cbe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  i2cbe_back #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_ticks_i (half_ticks),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign scl_level_o  = result.pins.scl;
  assign sda_enable_o = result.pins.en;
  assign sda_level_o  = result.pins.lvl;
  assign busy_res_o   = result.busy;
  assign done_res_o   = result.done;
  assign rx_byte_o    = result.rx_byte;
  assign ack_in_o     = result.ack_in;

  `I2CBE_ASSERT_IMPL(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o, "done while busy")
  `I2CBE_ASSERT_IMPL(a_lvl_needs_en, out_valid_o && sda_level_o, sda_enable_o, "SDA level set while released")
  `I2CBE_ASSERT_NEXT(a_accept_tracked, in_valid_i && in_ready_o, queue_valid || out_valid_o, "accepted tick vanished")

endmodule
